FILE: sv/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types, status bit positions and register indexes for the battery
// module limit monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

  localparam int IDX_W        = 5;
  localparam int VOLT_W       = 16;
  localparam int TEMP_W       = 16;
  localparam int STATUS_W     = 13;
  localparam int PACK_W       = 14;
  localparam int MAX_TEMP_W   = 15;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 3;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 48;

  localparam int DEFAULT_MODULE_COUNT = 32;
  // A 5-bit module index can only address this many modules.
  localparam int INDEX_SPAN = 1 << IDX_W;

  // Status bit positions.
  localparam int B_UV    = 0;
  localparam int B_OV    = 1;
  localparam int B_SHORT = 2;
  localparam int B_OT    = 3;
  localparam int B_TRNG  = 4;
  localparam int B_LLIM  = 5;
  localparam int B_HLIM  = 6;
  localparam int B_CHOT  = 7;
  localparam int B_WHV   = 8;
  localparam int B_WLV   = 9;
  localparam int B_WHT   = 10;
  localparam int B_WLT   = 11;
  localparam int B_BAL   = 12;
  localparam int B_REGEN = 13;

  localparam int FAULT_BITS = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TEMP_FAULT     = 3'd0,
    CFG_TEMP_TRIP_WARN = 3'd1,
    CFG_VOLT_FAULT     = 3'd2,
    CFG_VOLT_TRIP_WARN = 3'd3,
    CFG_VOLT_HYST      = 3'd4
  } cfg_index_t;

  // Limits as used by the status update.
  typedef struct packed {
    logic signed [TEMP_W-1:0] ot_discharge;
    logic signed [TEMP_W-1:0] ot_charging;
    logic signed [TEMP_W-1:0] range_high;
    logic signed [TEMP_W-1:0] range_low;
    logic signed [TEMP_W-1:0] chot_trip;
    logic signed [TEMP_W-1:0] warn_high_temp;
    logic signed [TEMP_W-1:0] warn_low_temp;
    logic signed [TEMP_W-1:0] temp_hyst;
    logic [VOLT_W-1:0]        undervolt;
    logic [VOLT_W-1:0]        overvolt;
    logic [VOLT_W-1:0]        short_volt;
    logic [VOLT_W-1:0]        low_limit;
    logic [VOLT_W-1:0]        high_limit;
    logic [VOLT_W-1:0]        warn_high_volt;
    logic [VOLT_W-1:0]        warn_low_volt;
    logic [VOLT_W-1:0]        volt_hyst;
  } blm_limits_t;

endpackage

FILE: sv/blm_status_update.sv
// ----------------------------------------------------------------------------
// blm_status_update
// Computes one module's new status word from its stored status, the
// measurement and the configured limits.
// ----------------------------------------------------------------------------
module blm_status_update
  import blm_pkg::*;
(
  input  blm_limits_t              limits,
  input  logic [STATUS_W-1:0]      prev_status,
  input  logic [VOLT_W-1:0]        volt,
  input  logic signed [TEMP_W-1:0] temp,
  input  logic                     charging,
  input  logic                     balancing,
  output logic [STATUS_W-1:0]      new_status
);

  // One extra bit keeps threshold plus hysteresis exact.
  logic [VOLT_W:0]          v_ext;
  logic [VOLT_W:0]          vh_ext;
  logic signed [TEMP_W:0]   t_ext;
  logic signed [TEMP_W:0]   th_ext;

  logic llim_set, llim_clr, hlim_set, hlim_clr;
  logic whv_set, whv_clr, wlv_set, wlv_clr;
  logic chot_set, chot_clr, wht_set, wht_clr, wlt_set, wlt_clr;

  assign v_ext  = {1'b0, volt};
  assign vh_ext = v_ext + {1'b0, limits.volt_hyst};
  assign t_ext  = {temp[TEMP_W-1], temp};
  assign th_ext = t_ext + {limits.temp_hyst[TEMP_W-1], limits.temp_hyst};

  // A clear of "below threshold minus hysteresis" is tested as
  // "value plus hysteresis below threshold", which never goes negative.
  assign llim_set = volt <= limits.low_limit;
  assign llim_clr = v_ext > ({1'b0, limits.low_limit} + {1'b0, limits.volt_hyst});
  assign hlim_set = volt >= limits.high_limit;
  assign hlim_clr = vh_ext < {1'b0, limits.high_limit};
  assign whv_set  = volt >= limits.warn_high_volt;
  assign whv_clr  = vh_ext < {1'b0, limits.warn_high_volt};
  assign wlv_set  = volt <= limits.warn_low_volt;
  assign wlv_clr  = v_ext > ({1'b0, limits.warn_low_volt} + {1'b0, limits.volt_hyst});

  assign chot_set = temp >= limits.chot_trip;
  assign chot_clr = th_ext < $signed({limits.chot_trip[TEMP_W-1], limits.chot_trip});
  assign wht_set  = temp >= limits.warn_high_temp;
  assign wht_clr  = th_ext < $signed({limits.warn_high_temp[TEMP_W-1],
                                      limits.warn_high_temp});
  assign wlt_set  = temp <= limits.warn_low_temp;
  assign wlt_clr  = t_ext > $signed({limits.warn_low_temp[TEMP_W-1], limits.warn_low_temp}
                    + {limits.temp_hyst[TEMP_W-1], limits.temp_hyst});

  always_comb begin
    new_status = prev_status;
    new_status[B_BAL] = balancing;

    if (volt <= limits.undervolt) new_status[B_UV] = 1'b1;
    if (volt >= limits.overvolt) new_status[B_OV] = 1'b1;
    if (volt <= limits.short_volt) new_status[B_SHORT] = 1'b1;
    if (llim_set) new_status[B_LLIM] = 1'b1;
    else if (llim_clr) new_status[B_LLIM] = 1'b0;
    if (hlim_set) new_status[B_HLIM] = 1'b1;
    else if (hlim_clr) new_status[B_HLIM] = 1'b0;
    if (whv_set) new_status[B_WHV] = 1'b1;
    else if (whv_clr) new_status[B_WHV] = 1'b0;
    if (wlv_set) new_status[B_WLV] = 1'b1;
    else if (wlv_clr) new_status[B_WLV] = 1'b0;

    if (temp >= limits.ot_discharge) new_status[B_OT] = 1'b1;
    if (charging && (temp >= limits.ot_charging)) new_status[B_OT] = 1'b1;
    if ((temp >= limits.range_high) || (temp <= limits.range_low)) begin
      new_status[B_TRNG] = 1'b1;
    end
    if (chot_set) new_status[B_CHOT] = 1'b1;
    else if (chot_clr) new_status[B_CHOT] = 1'b0;
    if (wht_set) new_status[B_WHT] = 1'b1;
    else if (wht_clr) new_status[B_WHT] = 1'b0;
    if (wlt_set) new_status[B_WLT] = 1'b1;
    else if (wlt_clr) new_status[B_WLT] = 1'b0;
  end

endmodule

FILE: sv/battery_module_limit_monitor_top.sv
// ----------------------------------------------------------------------------
// battery_module_limit_monitor_top
// Per-module voltage and temperature limit monitor with pack status roll-up.
// ----------------------------------------------------------------------------
// The block takes one module measurement per clock while the output is not
// stalled and returns one result per measurement, from the input register
// through the result register. The sustained rate is one item per cycle
// while unstalled: a module's status is read, updated and written back in
// the same cycle in which the result register loads, so a measurement for
// the same module may follow immediately. Sticky faults and the per-module
// status store clear only by reset; the pack word and the running maximum
// temperature clear after tlast; an index >= MODULE_COUNT changes nothing else.
module battery_module_limit_monitor_top
  import blm_pkg::*;
#(
  parameter int MODULE_COUNT = DEFAULT_MODULE_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Measurement stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // module_index[4:0], cell_voltage[20:5], module_temperature[36:21],
  // charging[37], balancing[38], zero[39]
  input  logic [IN_DATA_W-1:0]   s_tdata,
  input  logic                   s_tlast,
  // Result stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // module_status[12:0], pack_status[26:13], peak_temp[41:27],
  // zero[47:42]
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic                   m_tlast
);

  localparam int STORE_DEPTH = (MODULE_COUNT < INDEX_SPAN) ? MODULE_COUNT : INDEX_SPAN;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CMP_W       = 7;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] temp_fault_limits;
  logic [CFG_DATA_W-1:0] temp_trip_warn_limits;
  logic [47:0]           volt_fault_limits;
  logic [CFG_DATA_W-1:0] volt_trip_warn_limits;
  logic [VOLT_W-1:0]     volt_hysteresis;
  blm_limits_t           limits;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_fault_limits     <= '0;
      temp_trip_warn_limits <= '0;
      volt_fault_limits     <= '0;
      volt_trip_warn_limits <= '0;
      volt_hysteresis       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEMP_FAULT:     temp_fault_limits     <= cfg_data;
        CFG_TEMP_TRIP_WARN: temp_trip_warn_limits <= cfg_data;
        CFG_VOLT_FAULT:     volt_fault_limits     <= cfg_data[47:0];
        CFG_VOLT_TRIP_WARN: volt_trip_warn_limits <= cfg_data;
        CFG_VOLT_HYST:      volt_hysteresis       <= cfg_data[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    limits.ot_discharge   = temp_fault_limits[15:0];
    limits.ot_charging    = temp_fault_limits[31:16];
    limits.range_high     = temp_fault_limits[47:32];
    limits.range_low      = temp_fault_limits[63:48];
    limits.chot_trip      = temp_trip_warn_limits[15:0];
    limits.warn_high_temp = temp_trip_warn_limits[31:16];
    limits.warn_low_temp  = temp_trip_warn_limits[47:32];
    limits.temp_hyst      = temp_trip_warn_limits[63:48];
    limits.undervolt      = volt_fault_limits[15:0];
    limits.overvolt       = volt_fault_limits[31:16];
    limits.short_volt     = volt_fault_limits[47:32];
    limits.low_limit      = volt_trip_warn_limits[15:0];
    limits.high_limit     = volt_trip_warn_limits[31:16];
    limits.warn_high_volt = volt_trip_warn_limits[47:32];
    limits.warn_low_volt  = volt_trip_warn_limits[63:48];
    limits.volt_hyst      = volt_hysteresis;
  end

  // Input register stage.
  logic                     s1_valid;
  logic [IDX_W-1:0]         s1_index;
  logic [VOLT_W-1:0]        s1_volt;
  logic signed [TEMP_W-1:0] s1_temp;
  logic                     s1_charging;
  logic                     s1_balancing;
  logic                     s1_last;

  logic out_free;
  logic advance;
  logic in_xfer;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_index     <= s_tdata[4:0];
      s1_volt      <= s_tdata[20:5];
      s1_temp      <= s_tdata[36:21];
      s1_charging  <= s_tdata[37];
      s1_balancing <= s_tdata[38];
      s1_last      <= s_tlast;
    end
  end

  // Module status store and pack accumulation.
  logic [STATUS_W-1:0]   status_store [STORE_DEPTH];
  logic [STATUS_W-1:0]   pack_acc;
  logic [MAX_TEMP_W-1:0] run_max;

  logic                  in_range;
  logic [ADDR_W-1:0]     store_addr;
  logic [STATUS_W-1:0]   prev_status;
  logic [STATUS_W-1:0]   upd_status;
  logic [STATUS_W-1:0]   mod_status;
  logic [STATUS_W-1:0]   pack_acc_next;
  logic [MAX_TEMP_W-1:0] run_max_next;
  logic                  regen_off;
  logic [PACK_W-1:0]     pack_status;
  logic [MAX_TEMP_W-1:0] max_temp_out;

  assign in_range    = CMP_W'(s1_index) < CMP_W'(MODULE_COUNT);
  assign store_addr  = ADDR_W'(s1_index);
  assign prev_status = in_range ? status_store[store_addr] : '0;

  blm_status_update u_status_update (
    .limits      (limits),
    .prev_status (prev_status),
    .volt        (s1_volt),
    .temp        (s1_temp),
    .charging    (s1_charging),
    .balancing   (s1_balancing),
    .new_status  (upd_status)
  );

  always_comb begin
    mod_status    = in_range ? upd_status : '0;
    pack_acc_next = pack_acc | mod_status;
    // The running maximum starts at zero, so it is never negative.
    if (in_range && (s1_temp > $signed({1'b0, run_max}))) begin
      run_max_next = s1_temp[MAX_TEMP_W-1:0];
    end else begin
      run_max_next = run_max;
    end
    regen_off = (|pack_acc_next[FAULT_BITS-1:0]) || pack_acc_next[B_CHOT]
                || pack_acc_next[B_HLIM];
    pack_status  = s1_last ? {regen_off, pack_acc_next} : '0;
    max_temp_out = s1_last ? run_max_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        status_store[i] <= '0;
      end
    end else if (advance && in_range) begin
      status_store[store_addr] <= upd_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_acc <= '0;
      run_max  <= '0;
    end else if (advance) begin
      pack_acc <= s1_last ? '0 : pack_acc_next;
      run_max  <= s1_last ? '0 : run_max_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'b0, max_temp_out, pack_status, mod_status};
      m_tlast <= s1_last;
    end
  end

  // Checks.
  a_advance_loads_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("staged item did not reach the result register");

  a_pack_zero_midscan: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[41:13] == '0))
    else $error("pack fields nonzero on a transfer that does not end a scan");

  a_regen_matches: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[13 + B_REGEN] ==
      ((|m_tdata[13 +: FAULT_BITS]) || m_tdata[13 + B_CHOT] || m_tdata[13 + B_HLIM])))
    else $error("regen-off bit disagrees with pack status");

  a_scan_end_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> ((pack_acc == '0) && (run_max == '0)))
    else $error("pack accumulation not cleared at scan end");

endmodule

FILE: tb/tb_battery_module_limit_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_module_limit_monitor_top
// Self-checking bench for the battery module limit monitor. A behavioral
// model of the per-module status store, the pack roll-up and the running
// maximum temperature predicts every result. The checker compares each
// result transfer field by field with the oldest prediction. Stimulus is a
// short directed set followed by randomized pack scans and noise. It runs
// under several limit sets and with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb_battery_module_limit_monitor_top;
  import blm_pkg::*;

  localparam int MODULE_COUNT = DEFAULT_MODULE_COUNT;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic [VOLT_W-1:0]        volt;
    logic signed [TEMP_W-1:0] temp;
    logic                     chg;
    logic                     bal;
    logic                     last;
  } meas_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [PACK_W-1:0]     pack;
    logic [MAX_TEMP_W-1:0] max_temp;
    logic                  pack_valid;
  } result_t;

  typedef enum {LIM_NOMINAL, LIM_JITTER, LIM_RANDOM, LIM_ZERO, LIM_ONES} limit_set_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;

  battery_module_limit_monitor_top #(.MODULE_COUNT(MODULE_COUNT)) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Model copies of the limit registers and of the block state.
  logic [63:0]         temp_fault_q;
  logic [63:0]         temp_tw_q;
  logic [63:0]         volt_fault_q;
  logic [63:0]         volt_tw_q;
  logic [15:0]         volt_hyst_q;
  logic [STATUS_W-1:0] status_mem [MODULE_COUNT];
  logic [STATUS_W-1:0] pack_acc;
  int                  max_temp_run;

  result_t pending_results[$];
  result_t exp_r;

  int errors;
  int items_sent;
  int results_checked;
  int scans_done;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------
  function automatic int ufld(logic [63:0] r, int k);
    return int'(r[16*k +: 16]);
  endfunction

  function automatic int sfld(logic [63:0] r, int k);
    return int'($signed(r[16*k +: 16]));
  endfunction

  function automatic logic [STATUS_W-1:0] apply_hyst(logic [STATUS_W-1:0] s, int b,
                                                     bit set_c, bit clr_c);
    if (set_c) s[b] = 1'b1;
    else if (clr_c) s[b] = 1'b0;
    return s;
  endfunction

  function automatic result_t update_status_model(meas_t m);
    logic [STATUS_W-1:0] s;
    logic [PACK_W-1:0]   pk;
    result_t             r;
    int                  v;
    int                  t;
    int                  h;
    int                  lim;
    r = '0;
    s = '0;
    v = int'(m.volt);
    t = int'($signed(m.temp));
    if (int'(m.idx) < MODULE_COUNT) begin
      s = status_mem[m.idx];
      s[B_BAL] = m.bal;
      if (v <= ufld(volt_fault_q, 0)) s[B_UV] = 1'b1;
      if (v >= ufld(volt_fault_q, 1)) s[B_OV] = 1'b1;
      if (v <= ufld(volt_fault_q, 2)) s[B_SHORT] = 1'b1;
      // Thresholds with hysteresis are formed in 32 bits, so nothing wraps.
      h = int'(volt_hyst_q);
      lim = ufld(volt_tw_q, 0);
      s = apply_hyst(s, B_LLIM, v <= lim, v > lim + h);
      lim = ufld(volt_tw_q, 1);
      s = apply_hyst(s, B_HLIM, v >= lim, v < lim - h);
      lim = ufld(volt_tw_q, 2);
      s = apply_hyst(s, B_WHV, v >= lim, v < lim - h);
      lim = ufld(volt_tw_q, 3);
      s = apply_hyst(s, B_WLV, v <= lim, v > lim + h);
      if (t >= sfld(temp_fault_q, 0)) s[B_OT] = 1'b1;
      if (m.chg && t >= sfld(temp_fault_q, 1)) s[B_OT] = 1'b1;
      if (t >= sfld(temp_fault_q, 2) || t <= sfld(temp_fault_q, 3)) s[B_TRNG] = 1'b1;
      h = sfld(temp_tw_q, 3);
      lim = sfld(temp_tw_q, 0);
      s = apply_hyst(s, B_CHOT, t >= lim, t < lim - h);
      lim = sfld(temp_tw_q, 1);
      s = apply_hyst(s, B_WHT, t >= lim, t < lim - h);
      lim = sfld(temp_tw_q, 2);
      s = apply_hyst(s, B_WLT, t <= lim, t > lim + h);
      status_mem[m.idx] = s;
      pack_acc = pack_acc | s;
      if (t > max_temp_run) max_temp_run = t;
    end
    r.status = s;
    r.pack_valid = m.last;
    if (m.last) begin
      pk = {1'b0, pack_acc};
      if ((|pack_acc[FAULT_BITS-1:0]) || pack_acc[B_CHOT] || pack_acc[B_HLIM])
        pk[B_REGEN] = 1'b1;
      r.pack = pk;
      // The running maximum starts at zero, so it is never negative.
      r.max_temp = max_temp_run[MAX_TEMP_W-1:0];
      pack_acc = '0;
      max_temp_run = 0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic meas_t make_meas(int idx, int v, int t, bit chg, bit bal, bit last);
    meas_t m;
    m.idx  = idx[IDX_W-1:0];
    m.volt = v[VOLT_W-1:0];
    m.temp = t[TEMP_W-1:0];
    m.chg  = chg;
    m.bal  = bal;
    m.last = last;
    return m;
  endfunction

  function automatic logic [63:0] pack4(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  function automatic int jitter(int n);
    return int'($urandom_range(0, 2 * n)) - n;
  endfunction

  // Mostly values close to one of the current thresholds, some uniform.
  function automatic int pick_voltage();
    int base;
    int span;
    int v;
    if ($urandom_range(0, 99) < 15) return int'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) == 0) base = ufld(volt_fault_q, $urandom_range(0, 2));
    else base = ufld(volt_tw_q, $urandom_range(0, 3));
    span = int'(volt_hyst_q) + 8;
    if (span > 4096) span = 4096;
    v = base + jitter(span);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  function automatic int pick_temperature();
    int base;
    int span;
    int t;
    if ($urandom_range(0, 99) < 10) return int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 9) == 0) base = sfld(temp_fault_q, $urandom_range(0, 3));
    else base = sfld(temp_tw_q, $urandom_range(0, 2));
    span = sfld(temp_tw_q, 3);
    if (span < 0) span = -span;
    span = span + 8;
    if (span > 4096) span = 4096;
    t = base + jitter(span);
    if (t < -32768) t = -32768;
    if (t > 32767) t = 32767;
    return t;
  endfunction

  function automatic meas_t random_meas(int idx, bit last);
    return make_meas(idx, pick_voltage(), pick_temperature(),
                     $urandom_range(0, 1), $urandom_range(0, 1), last);
  endfunction

  // Called and returning at a falling edge. Valid stays high between
  // back-to-back items.
  task automatic send_item(meas_t m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata  = {1'b0, m.bal, m.chg, m.temp, m.volt, m.idx};
    s_tlast  = m.last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(update_status_model(m));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit_reg(cfg_index_t idx, logic [63:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_TEMP_FAULT:     temp_fault_q = val;
      CFG_TEMP_TRIP_WARN: temp_tw_q    = val;
      CFG_VOLT_FAULT:     volt_fault_q = val;
      CFG_VOLT_TRIP_WARN: volt_tw_q    = val;
      CFG_VOLT_HYST:      volt_hyst_q  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_limits(limit_set_t kind);
    case (kind)
      LIM_NOMINAL: begin
        write_limit_reg(CFG_TEMP_FAULT, pack4(600, 450, 650, -200));
        write_limit_reg(CFG_TEMP_TRIP_WARN, pack4(430, 500, 0, 20));
        write_limit_reg(CFG_VOLT_FAULT, pack4(3000, 62000, 1000, 0));
        write_limit_reg(CFG_VOLT_TRIP_WARN, pack4(20000, 55000, 50000, 25000));
        write_limit_reg(CFG_VOLT_HYST, 64'd300);
      end
      LIM_JITTER: begin
        write_limit_reg(CFG_TEMP_FAULT, pack4(600 + jitter(100), 450 + jitter(100),
                                              650 + jitter(100), -200 + jitter(100)));
        // A negative temperature hysteresis shows up here now and then.
        write_limit_reg(CFG_TEMP_TRIP_WARN, pack4(430 + jitter(100), 500 + jitter(100),
                                                  jitter(100), jitter(200) + 150));
        write_limit_reg(CFG_VOLT_FAULT, pack4(3000 + jitter(2000), 62000 + jitter(2000),
                                              1000 + jitter(500), 0));
        write_limit_reg(CFG_VOLT_TRIP_WARN, pack4(20000 + jitter(3000), 55000 + jitter(3000),
                                                  50000 + jitter(3000), 25000 + jitter(3000)));
        write_limit_reg(CFG_VOLT_HYST, 64'($urandom_range(0, 2000)));
      end
      LIM_RANDOM: begin
        write_limit_reg(CFG_TEMP_FAULT, {$urandom, $urandom});
        write_limit_reg(CFG_TEMP_TRIP_WARN, {$urandom, $urandom});
        write_limit_reg(CFG_VOLT_FAULT, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
        write_limit_reg(CFG_VOLT_TRIP_WARN, {$urandom, $urandom});
        write_limit_reg(CFG_VOLT_HYST, 64'($urandom_range(0, 65535)));
      end
      LIM_ZERO: begin
        write_limit_reg(CFG_TEMP_FAULT, '0);
        write_limit_reg(CFG_TEMP_TRIP_WARN, '0);
        write_limit_reg(CFG_VOLT_FAULT, '0);
        write_limit_reg(CFG_VOLT_TRIP_WARN, '0);
        write_limit_reg(CFG_VOLT_HYST, '0);
      end
      default: begin
        write_limit_reg(CFG_TEMP_FAULT, '1);
        write_limit_reg(CFG_TEMP_TRIP_WARN, '1);
        write_limit_reg(CFG_VOLT_FAULT, 64'hFFFF_FFFF_FFFF);
        write_limit_reg(CFG_VOLT_TRIP_WARN, '1);
        write_limit_reg(CFG_VOLT_HYST, 64'hFFFF);
      end
    endcase
  endtask

  // Mostly complete scans starting at module 0, the rest loose measurements
  // with a random index and an occasional early end of scan.
  task automatic run_traffic(int n_items);
    int sent;
    int len;
    int k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 9) == 0) ? MODULE_COUNT : $urandom_range(1, 12);
        for (k = 0; k < len; k++) send_item(random_meas(k, k == len - 1));
      end else begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          send_item(random_meas($urandom_range(0, MODULE_COUNT - 1), $urandom_range(0, 7) == 0));
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Uses the upper modules only, so their sticky faults stay out of the way
  // of the short random scans.
  task automatic test_directed_limits();
    load_limits(LIM_NOMINAL);
    send_item(make_meas(24, 30000, 250, 0, 1, 0));
    // Low limit, low-voltage warning, high-temp warning and charge overtemp.
    send_item(make_meas(25, 20000, 500, 1, 0, 1));
    // Inside the hysteresis band: trip and warning bits hold.
    send_item(make_meas(25, 20300, 480, 0, 0, 0));
    // Just past the band: the low-limit trip and the high-temp warning clear.
    send_item(make_meas(25, 20301, 479, 0, 0, 1));
    send_item(make_meas(26, 0, -32768, 0, 1, 0));
    send_item(make_meas(27, 65535, 32767, 1, 0, 1));
    // A scan of only negative temperatures reports a maximum of zero.
    send_item(make_meas(28, 30000, -5, 0, 0, 0));
    send_item(make_meas(29, 30000, -100, 1, 1, 0));
    send_item(make_meas(30, 30000, -32768, 0, 0, 1));
    send_item(make_meas(31, 30000, 0, 0, 0, 1));
    wait_idle();
  endtask

  task automatic test_hysteresis_extremes();
    write_limit_reg(CFG_VOLT_HYST, 64'hFFFF);
    write_limit_reg(CFG_TEMP_TRIP_WARN, pack4(430, 500, 0, 32767));
    send_item(make_meas(29, 65535, 32767, 0, 0, 0));
    send_item(make_meas(29, 0, -32768, 1, 0, 1));
    wait_idle();
    write_limit_reg(CFG_TEMP_TRIP_WARN, pack4(430, 500, 0, -32768));
    send_item(make_meas(29, 40000, 0, 0, 1, 1));
    wait_idle();
    load_limits(LIM_NOMINAL);
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // pipeline fills and the input has to stall.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 150;
    run_traffic(60);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_traffic(450);
    wait_idle();

    load_limits(LIM_JITTER);
    send_idle_pct = 55;
    run_traffic(450);
    wait_idle();

    load_limits(LIM_JITTER);
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    run_traffic(450);
    wait_idle();

    send_idle_pct  = 12;
    recv_stall_pct = 12;
    load_limits(LIM_RANDOM);
    run_traffic(200);
    wait_idle();
    load_limits(LIM_ZERO);
    run_traffic(100);
    wait_idle();
    load_limits(LIM_ONES);
    run_traffic(100);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        m_tready = 1'b0;
        hold_off_left--;
      end else begin
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic compare_field(string name, logic [15:0] expv, logic [15:0] got);
    if (expv !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("time %0t: %s mismatch, expected %h, actual %h", $time, name, expv, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("time %0t: unexpected result transfer, expected none, actual %h",
                   $time, m_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("module_status", 16'(exp_r.status), 16'(m_tdata[12:0]));
        compare_field("pack_status", 16'(exp_r.pack), 16'(m_tdata[26:13]));
        compare_field("peak_temp", 16'(exp_r.max_temp), 16'(m_tdata[41:27]));
        compare_field("pack_valid", 16'(exp_r.pack_valid), 16'(m_tlast));
        results_checked++;
        if (exp_r.pack_valid) scans_done++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("time %0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_TEMP_FAULT;
    cfg_data        = '0;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    s_tlast         = 1'b0;
    temp_fault_q    = '0;
    temp_tw_q       = '0;
    volt_fault_q    = '0;
    volt_tw_q       = '0;
    volt_hyst_q     = '0;
    pack_acc        = '0;
    max_temp_run    = 0;
    errors          = 0;
    items_sent      = 0;
    results_checked = 0;
    scans_done      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_left   = 0;
    for (int i = 0; i < MODULE_COUNT; i++) status_mem[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_limits();
    test_hysteresis_extremes();
    test_output_backpressure();
    test_random_traffic();

    $display("Covered %0d measurements, %0d results checked, %0d scans, in %0d cycles.",
             items_sent, results_checked, scans_done, cycle_count);
    $display("Limit sets: nominal, jittered, random, all-zero, all-ones; idle and stall mixes.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
